[rtl/mdap_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdap_pkg: shared types and constants for the multichannel decimator
// Field widths, config register indexes and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package mdap_pkg;

  // field widths
  localparam int SAMPLE_W   = 16;
  localparam int CHAN_W     = 3;
  localparam int FACTOR_W   = 11;
  localparam int ACC_W      = 32;
  localparam int DIVIDEND_W = ACC_W + 1;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int PROD_W     = SAMPLE_W + FACTOR_W + 1;

  // config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = FACTOR_W;

  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd1;

  // parameter defaults
  localparam int DEF_CHANNELS   = 8;
  localparam int DEF_MAX_FACTOR = 1024;

  // saturation limits
  localparam logic [SAMPLE_W-1:0] SAT_POS = 16'h7fff;
  localparam logic [SAMPLE_W-1:0] SAT_NEG = 16'h8000;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic div_start;
    logic sat;
    logic mul;
    logic fix;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ch_ok;
    logic pass;
    logic block_end;
    logic avg;
    logic div_done;
    logic slot_free;
  } dp_status_t;

endpackage

[rtl/mdap_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdap_in_if: input sample channel
// Valid/ready handshake carrying one channel-tagged sample per word.
// ----------------------------------------------------------------------------
interface mdap_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mdap_pkg::SAMPLE_W-1:0] sample_in;
  logic        [mdap_pkg::CHAN_W-1:0]   channel_in;

  modport source (output valid, output sample_in, output channel_in, input ready);
  modport sink   (input valid, input sample_in, input channel_in, output ready);
endinterface

[rtl/mdap_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdap_out_if: decimated sample channel
// Valid/ready handshake carrying one channel-tagged result per word.
// ----------------------------------------------------------------------------
interface mdap_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mdap_pkg::SAMPLE_W-1:0] sample_out;
  logic        [mdap_pkg::CHAN_W-1:0]   channel_out;

  modport source (output valid, output sample_out, output channel_out, input ready);
  modport sink   (input valid, input sample_out, input channel_out, output ready);
endinterface

[rtl/mdap_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdap_div: bit-serial signed divider
// Restoring division of a signed dividend by an unsigned factor, one
// quotient bit per cycle; returns quotient magnitude and sign.
// ----------------------------------------------------------------------------
module mdap_div (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [mdap_pkg::DIVIDEND_W-1:0] dividend,
  input  logic        [mdap_pkg::FACTOR_W-1:0]   divisor,
  output logic                                   done,
  output logic        [mdap_pkg::DIVIDEND_W-1:0] quo,
  output logic                                   neg
);

  localparam int STEP_W = $clog2(mdap_pkg::DIV_STEPS);

  logic                                busy;
  logic [STEP_W-1:0]                   step;
  logic [mdap_pkg::FACTOR_W-1:0]       rem;
  logic [mdap_pkg::FACTOR_W-1:0]       dvs;
  logic [mdap_pkg::FACTOR_W:0]         trial;
  logic                                ge;
  logic [mdap_pkg::FACTOR_W-1:0]       rem_next;

  // one restoring step
  always_comb begin
    trial    = {rem, quo[mdap_pkg::DIVIDEND_W-1]};
    ge       = trial >= {1'b0, dvs};
    rem_next = ge ? mdap_pkg::FACTOR_W'(trial - {1'b0, dvs})
                  : mdap_pkg::FACTOR_W'(trial);
  end

  // iteration control and shift registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        neg  <= dividend[mdap_pkg::DIVIDEND_W-1];
        quo  <= dividend[mdap_pkg::DIVIDEND_W-1] ? -dividend : dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        rem  <= rem_next;
        quo  <= {quo[mdap_pkg::DIVIDEND_W-2:0], ge};
        step <= step + 1'b1;
        if (step == STEP_W'(mdap_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem < dvs) else $error("divider remainder out of range");

  // done follows the final step only
  a_done_end: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy)) else $error("divider done without run");

endmodule

[rtl/mdap_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdap_dpath: decimator datapath
// Config registers, per-channel accumulator/count/peak state, rounding
// divider, remainder multiply and the output register.
// ----------------------------------------------------------------------------
module mdap_dpath #(
  parameter int CHANNELS   = mdap_pkg::DEF_CHANNELS,
  parameter int MAX_FACTOR = mdap_pkg::DEF_MAX_FACTOR
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic        [mdap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [mdap_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic signed [mdap_pkg::SAMPLE_W-1:0]   sample_in,
  input  logic        [mdap_pkg::CHAN_W-1:0]     channel_in,
  input  logic                                   dout_ready,
  output logic                                   dout_valid,
  output logic signed [mdap_pkg::SAMPLE_W-1:0]   sample_out,
  output logic        [mdap_pkg::CHAN_W-1:0]     channel_out,
  input  mdap_pkg::dp_cmd_t                      cmd,
  output mdap_pkg::dp_status_t                   st
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // config registers
  logic [mdap_pkg::FACTOR_W-1:0] decim_factor;
  logic                          use_average;
  logic [mdap_pkg::FACTOR_W-1:0] fct;

  // per-channel state
  logic [mdap_pkg::ACC_W-1:0]    accumulator [CHANNELS];
  logic [mdap_pkg::FACTOR_W-1:0] sample_count [CHANNELS];
  logic [mdap_pkg::SAMPLE_W-1:0] block_peak [CHANNELS];

  // item and work registers
  logic signed [mdap_pkg::SAMPLE_W-1:0] smp;
  logic        [mdap_pkg::CHAN_W-1:0]   chn;
  logic        [mdap_pkg::ACC_W-1:0]    acc_hold;
  logic signed [mdap_pkg::SAMPLE_W-1:0] q_sat;
  logic signed [mdap_pkg::PROD_W-1:0]   prod;
  logic        [mdap_pkg::SAMPLE_W-1:0] res;

  logic [CH_W-1:0]                      idx;
  logic [mdap_pkg::ACC_W-1:0]           acc_sum;
  logic [mdap_pkg::SAMPLE_W-1:0]        mag;
  logic [mdap_pkg::SAMPLE_W-1:0]        peak_new;
  logic [mdap_pkg::FACTOR_W:0]          cnt_inc;
  logic signed [mdap_pkg::DIVIDEND_W-1:0] dividend;
  logic                                 div_done;
  logic [mdap_pkg::DIVIDEND_W-1:0]      qmag;
  logic                                 qneg;
  logic                                 clear_all;

  // effective factor: zero acts as one, large values clamp
  always_comb begin
    if (decim_factor == '0) begin
      fct = mdap_pkg::FACTOR_W'(1);
    end else if (32'(decim_factor) > MAX_FACTOR) begin
      fct = mdap_pkg::FACTOR_W'(MAX_FACTOR);
    end else begin
      fct = decim_factor;
    end
  end

  // item evaluation
  always_comb begin
    idx      = CH_W'(chn);
    acc_sum  = accumulator[idx] + mdap_pkg::ACC_W'(smp);
    if (!smp[mdap_pkg::SAMPLE_W-1]) begin
      mag = smp;
    end else if (smp == $signed(mdap_pkg::SAT_NEG)) begin
      mag = mdap_pkg::SAT_POS;
    end else begin
      mag = -smp;
    end
    peak_new = (mag > block_peak[idx]) ? mag : block_peak[idx];
    cnt_inc  = {1'b0, sample_count[idx]} + 1'b1;
    dividend = $signed({acc_hold[mdap_pkg::ACC_W-1], acc_hold})
             + $signed(mdap_pkg::DIVIDEND_W'(fct >> 1));
    clear_all = cfg_we && (cfg_index == mdap_pkg::CFG_FACTOR ||
                           cfg_index == mdap_pkg::CFG_MODE);
  end

  // status to the controller
  always_comb begin
    st.ch_ok     = 32'(chn) < CHANNELS;
    st.pass      = fct == mdap_pkg::FACTOR_W'(1);
    st.block_end = cnt_inc >= {1'b0, fct};
    st.avg       = use_average;
    st.div_done  = div_done;
    st.slot_free = !dout_valid || dout_ready;
  end

  mdap_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (fct),
    .done     (div_done),
    .quo      (qmag),
    .neg      (qneg)
  );

  // config registers and channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      decim_factor <= mdap_pkg::FACTOR_W'(1);
      use_average  <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == mdap_pkg::CFG_FACTOR) begin
        decim_factor <= cfg_data;
      end else if (cfg_index == mdap_pkg::CFG_MODE) begin
        use_average <= cfg_data[0];
      end
    end

    if (rst || clear_all) begin
      for (int c = 0; c < CHANNELS; c++) begin
        accumulator[c]  <= '0;
        sample_count[c] <= '0;
        block_peak[c]   <= '0;
      end
    end else if (cmd.eval && st.ch_ok && !st.pass) begin
      sample_count[idx] <= st.block_end ? '0 : mdap_pkg::FACTOR_W'(cnt_inc);
      if (use_average) begin
        accumulator[idx] <= acc_sum;
      end else begin
        block_peak[idx] <= st.block_end ? '0 : peak_new;
      end
    end else if (cmd.fix) begin
      // keep the remainder as dither
      accumulator[idx] <= acc_hold - mdap_pkg::ACC_W'(prod);
    end
  end

  // item capture and rounding pipeline
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp <= sample_in;
      chn <= channel_in;
    end
    if (cmd.eval) begin
      acc_hold <= acc_sum;
      res      <= st.pass ? smp : peak_new;
    end
    if (cmd.sat) begin
      if (!qneg) begin
        q_sat <= (qmag > mdap_pkg::DIVIDEND_W'(32767)) ? $signed(mdap_pkg::SAT_POS)
                                                        : $signed(qmag[15:0]);
      end else begin
        q_sat <= (qmag > mdap_pkg::DIVIDEND_W'(32768)) ? $signed(mdap_pkg::SAT_NEG)
                                                        : -$signed(qmag[15:0]);
      end
    end
    if (cmd.mul) begin
      prod <= $signed(mdap_pkg::PROD_W'(q_sat))
            * $signed(mdap_pkg::PROD_W'({1'b0, fct}));
      res  <= q_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dout_valid <= 1'b0;
    end else if (cmd.emit) begin
      dout_valid <= 1'b1;
    end else if (dout_ready) begin
      dout_valid <= 1'b0;
    end
    if (cmd.emit) begin
      sample_out  <= res;
      channel_out <= chn;
    end
  end

  // a pending word is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!dout_valid || dout_ready)) else $error("output word overwritten");

  // remainder write-back only happens in average mode
  a_fix_avg: assert property (@(posedge clk) disable iff (rst)
    cmd.fix |-> use_average) else $error("remainder update in peak mode");

endmodule

[rtl/mdap_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdap_ctrl: decimator controller
// Sequences one sample word through evaluate, then for an average result
// divide, saturate, multiply and remainder steps, and output for any result.
// ----------------------------------------------------------------------------
module mdap_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 din_valid,
  output logic                 din_ready,
  input  mdap_pkg::dp_status_t st,
  output mdap_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_PREP,
    S_DIV,
    S_SAT,
    S_MUL,
    S_FIX,
    S_EMIT
  } state_t;

  state_t state;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (din_valid) state <= S_EVAL;
        end
        S_EVAL: begin
          priority if (!st.ch_ok)    state <= S_IDLE;
          else if (st.pass)          state <= S_EMIT;
          else if (!st.block_end)    state <= S_IDLE;
          else if (st.avg)           state <= S_PREP;
          else                       state <= S_EMIT;
        end
        S_PREP: state <= S_DIV;
        S_DIV: begin
          if (st.div_done) state <= S_SAT;
        end
        S_SAT:  state <= S_MUL;
        S_MUL:  state <= S_FIX;
        S_FIX:  state <= S_EMIT;
        S_EMIT: begin
          if (st.slot_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // command decode
  always_comb begin
    din_ready     = state == S_IDLE;
    cmd.load      = (state == S_IDLE) && din_valid;
    cmd.eval      = state == S_EVAL;
    cmd.div_start = state == S_PREP;
    cmd.sat       = state == S_SAT;
    cmd.mul       = state == S_MUL;
    cmd.fix       = state == S_FIX;
    cmd.emit      = (state == S_EMIT) && st.slot_free;
  end

  // divider completion lands while waiting on it
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    st.div_done |-> state == S_DIV) else $error("divider done outside divide step");

  // no word taken while a division runs
  a_div_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && !st.div_done) |=> state == S_DIV)
    else $error("left divide step early");

endmodule

[rtl/multichannel_decimator_avg_peak_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_decimator_avg_peak_core: per-channel averaging/peak decimator
// Pass-through and peak words go from evaluation straight to the output
// register; an average block end first runs the 33-step divider.
// A new word is taken only once the last one is through, and a full
// output register holds the controller until the pending word leaves.
// Reset (rst, synchronous): factor 1, average mode, all channel state clear.
// ----------------------------------------------------------------------------
module multichannel_decimator_avg_peak_core #(
  parameter int CHANNELS   = mdap_pkg::DEF_CHANNELS,
  parameter int MAX_FACTOR = mdap_pkg::DEF_MAX_FACTOR
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mdap_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mdap_pkg::CFG_DATA_W-1:0]     cfg_data,
  mdap_in_if.sink                             din,
  mdap_out_if.source                          dout
);

  mdap_pkg::dp_cmd_t    cmd;
  mdap_pkg::dp_status_t st;

  // sequencing
  mdap_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .din_valid (din.valid),
    .din_ready (din.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // arithmetic and channel state
  mdap_dpath #(
    .CHANNELS   (CHANNELS),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_in   (din.sample_in),
    .channel_in  (din.channel_in),
    .dout_ready  (dout.ready),
    .dout_valid  (dout.valid),
    .sample_out  (dout.sample_out),
    .channel_out (dout.channel_out),
    .cmd         (cmd),
    .st          (st)
  );

endmodule

[verif/decim_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decim_checker: expected-word predictor and compare for the decimator
// Follows the register writes and every accepted input word, works out
// the decimated words per channel, and compares each accepted output word
// with the oldest one still waiting.
// ----------------------------------------------------------------------------
module decim_checker #(
  parameter int CHANNELS   = mdap_pkg::DEF_CHANNELS,
  parameter int MAX_FACTOR = mdap_pkg::DEF_MAX_FACTOR
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mdap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mdap_pkg::CFG_DATA_W-1:0] cfg_data,
  mdap_in_if                              din,
  mdap_out_if                             dout,
  output int                              words_pending,
  output int                              fail_count
);

  typedef struct packed {
    logic signed [mdap_pkg::SAMPLE_W-1:0] value;
    logic        [mdap_pkg::CHAN_W-1:0]   chan;
  } dec_word_t;

  // shadow of the registers and the per-channel state
  logic        [mdap_pkg::FACTOR_W-1:0] factor_reg;
  logic                                 avg_mode;
  logic signed [mdap_pkg::ACC_W-1:0]    chan_acc  [CHANNELS];
  int                                   chan_left [CHANNELS];
  int                                   chan_peak [CHANNELS];

  dec_word_t expected_words [$];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  // zero acts as pass-through, anything above the cap is clamped
  function automatic int active_factor();
    if (factor_reg == '0) begin
      return 1;
    end
    if (int'(factor_reg) > MAX_FACTOR) begin
      return MAX_FACTOR;
    end
    return int'(factor_reg);
  endfunction

  task automatic clear_channels();
    for (int c = 0; c < CHANNELS; c++) begin
      chan_acc[c]  = '0;
      chan_left[c] = active_factor();
      chan_peak[c] = 0;
    end
  endtask

  // one input word: update the channel and queue the word it completes
  task automatic decimate_sample(input logic signed [mdap_pkg::SAMPLE_W-1:0] smp,
                                 input logic [mdap_pkg::CHAN_W-1:0] ch);
    int        f;
    int        mag;
    longint    acc_sum;
    longint    quo;
    longint    rem;
    dec_word_t w;
    f = active_factor();
    if (int'(ch) >= CHANNELS) begin
      return;
    end
    if (f == 1) begin
      w.value = smp;
      w.chan  = ch;
      expected_words.push_back(w);
      return;
    end
    if (avg_mode) begin
      acc_sum      = longint'(chan_acc[ch]) + longint'(smp);
      chan_acc[ch] = acc_sum[mdap_pkg::ACC_W-1:0];
    end else begin
      mag = (smp < 0) ? -int'(smp) : int'(smp);
      if (mag > 32767) begin
        mag = 32767;
      end
      if (mag > chan_peak[ch]) begin
        chan_peak[ch] = mag;
      end
    end
    if (chan_left[ch] <= 1) begin
      chan_left[ch] = f;
      if (avg_mode) begin
        // rounded quotient, truncated toward zero, remainder kept as dither
        acc_sum = longint'(chan_acc[ch]);
        quo     = (acc_sum + longint'(f / 2)) / longint'(f);
        if (quo > 32767) begin
          quo = 32767;
        end
        if (quo < -32768) begin
          quo = -32768;
        end
        rem          = acc_sum - quo * longint'(f);
        chan_acc[ch] = rem[mdap_pkg::ACC_W-1:0];
      end else begin
        quo           = longint'(chan_peak[ch]);
        chan_peak[ch] = 0;
      end
      w.value = quo[mdap_pkg::SAMPLE_W-1:0];
      w.chan  = ch;
      expected_words.push_back(w);
    end else begin
      chan_left[ch]--;
    end
  endtask

  always @(posedge clk) begin
    dec_word_t exp_w;
    if (rst) begin
      factor_reg = mdap_pkg::FACTOR_W'(1);
      avg_mode   = 1'b1;
      clear_channels();
      expected_words.delete();
    end else begin
      // output side first so a word leaving frees its slot
      if (dout.valid && dout.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word ch=%0d sample=%0d",
                                    dout.channel_out, dout.sample_out));
        end else begin
          exp_w = expected_words.pop_front();
          if (dout.sample_out !== exp_w.value) begin
            report_mismatch($sformatf("ch %0d sample_out got %0d want %0d",
                                      exp_w.chan, dout.sample_out, exp_w.value));
          end
          if (dout.channel_out !== exp_w.chan) begin
            report_mismatch($sformatf("channel_out got %0d want %0d",
                                      dout.channel_out, exp_w.chan));
          end
        end
      end
      if (din.valid && din.ready) begin
        decimate_sample(din.sample_in, din.channel_in);
      end
      // register writes clear all channel state, spare indexes do nothing
      if (cfg_we) begin
        if (cfg_index == mdap_pkg::CFG_FACTOR) begin
          factor_reg = cfg_data;
          clear_channels();
        end else if (cfg_index == mdap_pkg::CFG_MODE) begin
          avg_mode = cfg_data[0];
          clear_channels();
        end
      end
    end
    words_pending <= expected_words.size();
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for multichannel_decimator_avg_peak_core
// Directed words for pass-through, zero factor, peak of the most negative
// sample and spare register indexes, random words over a series of
// factor/mode settings with random gaps on both sides, then a clamped factor.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [mdap_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [mdap_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 64;
  localparam int WORDS_PER_SET = 17;
  localparam int NUM_SETS      = 12;

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [mdap_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mdap_pkg::CFG_DATA_W-1:0] cfg_data;

  int src_idle_pct;
  int snk_idle_pct;
  int hold_kick;
  int hold_seen;
  int hold_left;
  int words_pending;
  int fail_count;

  int set_factor [NUM_SETS] = '{2, 1, 3, 0, 4, 5, 2, 7, 1, 16, 3, 33};
  bit set_avg    [NUM_SETS] = '{0, 1, 1, 0, 0, 1, 1, 0, 0, 1, 0, 1};

  mdap_in_if  din ();
  mdap_out_if dout ();

  multichannel_decimator_avg_peak_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din),
    .dout      (dout)
  );

  decim_checker u_chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .din           (din),
    .dout          (dout),
    .words_pending (words_pending),
    .fail_count    (fail_count)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // output side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      dout.ready <= 1'b0;
      hold_seen  <= 0;
      hold_left  <= 0;
    end else if (hold_left != 0) begin
      dout.ready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_kick != hold_seen) begin
      dout.ready <= 1'b0;
      hold_seen  <= hold_kick;
      hold_left  <= HOLD_CYCLES;
    end else begin
      dout.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  function automatic logic signed [mdap_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return mdap_pkg::SAT_POS;
      1: return mdap_pkg::SAT_NEG;
      2: return mdap_pkg::SAMPLE_W'($urandom_range(0, 16) - 8);
      default: return mdap_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  // offer one word after a random gap, return once it is taken
  task automatic push_sample(input logic signed [mdap_pkg::SAMPLE_W-1:0] smp,
                             input logic [mdap_pkg::CHAN_W-1:0] ch);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      din.valid <= 1'b0;
      @(posedge clk);
    end
    din.valid      <= 1'b1;
    din.sample_in  <= smp;
    din.channel_in <= ch;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
  endtask

  // stop sending and let every expected word come out
  task automatic wait_idle();
    din.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mdap_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mdap_pkg::CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // stimulus
  initial begin
    int                              f;
    int                              nch;
    int                              big_ch;
    logic [mdap_pkg::CFG_DATA_W-1:0] mode_word;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    din.valid      = 1'b0;
    din.sample_in  = '0;
    din.channel_in = '0;
    hold_kick      = 0;
    src_idle_pct   = 7;
    snk_idle_pct   = 48;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // pass-through after reset, extremes on every channel
    push_sample(mdap_pkg::SAT_POS, 3'd0);
    push_sample(mdap_pkg::SAT_NEG, 3'd1);
    push_sample(16'sd0, 3'd2);
    push_sample(-16'sd1, 3'd3);
    push_sample(16'sd1, 3'd4);
    push_sample(16'sh5555, 3'd5);
    push_sample(16'shaaaa, 3'd6);
    push_sample(-16'sd2, 3'd7);

    // zero factor behaves as pass-through
    write_reg(mdap_pkg::CFG_FACTOR, '0);
    push_sample(16'sd1234, 3'd6);
    push_sample(-16'sd1234, 3'd7);

    // peak mode, upper data bits set; most negative sample saturates
    write_reg(mdap_pkg::CFG_MODE, 11'h7fe);
    write_reg(mdap_pkg::CFG_FACTOR, 11'd2);
    push_sample(mdap_pkg::SAT_NEG, 3'd0);
    push_sample(16'sd5, 3'd0);
    push_sample(-16'sd3, 3'd1);
    push_sample(-16'sd32767, 3'd1);
    push_sample(16'sd100, 3'd2);
    push_sample(-16'sd200, 3'd2);

    // average mode at full scale
    write_reg(mdap_pkg::CFG_MODE, 11'd1);
    push_sample(mdap_pkg::SAT_POS, 3'd3);
    push_sample(mdap_pkg::SAT_POS, 3'd3);
    push_sample(mdap_pkg::SAT_NEG, 3'd4);
    push_sample(mdap_pkg::SAT_NEG, 3'd4);
    push_sample(mdap_pkg::SAT_NEG, 3'd4);
    push_sample(mdap_pkg::SAT_NEG, 3'd4);

    // spare indexes mid-block must keep the partial sum
    write_reg(mdap_pkg::CFG_FACTOR, 11'd3);
    push_sample(16'sd7, 3'd5);
    write_reg(CFG_SPARE_HI, 11'h7ff);
    write_reg(CFG_SPARE_LO, '0);
    push_sample(16'sd8, 3'd5);
    push_sample(-16'sd1, 3'd5);

    // random words over a sweep of settings
    for (int k = 0; k < NUM_SETS; k++) begin
      if (k < 4) begin
        src_idle_pct <= 7;
        snk_idle_pct <= 48;
      end else if (k < 8) begin
        src_idle_pct <= 48;
        snk_idle_pct <= 7;
      end else begin
        src_idle_pct <= 0;
        snk_idle_pct <= 0;
      end
      f         = set_factor[k];
      nch       = (f > 8) ? 2 : mdap_pkg::DEF_CHANNELS;
      mode_word = mdap_pkg::CFG_DATA_W'($urandom);
      mode_word[0] = set_avg[k];
      write_reg(mdap_pkg::CFG_FACTOR, mdap_pkg::CFG_DATA_W'(f));
      write_reg(mdap_pkg::CFG_MODE, mode_word);
      for (int n = 0; n < WORDS_PER_SET; n++) begin
        // long output hold-off while words keep coming
        if (k == 6 && n == 4) begin
          hold_kick <= hold_kick + 1;
        end
        push_sample(rand_sample(), mdap_pkg::CHAN_W'($urandom_range(0, nch - 1)));
      end
    end

    // largest data value clamps to the maximum factor: one full block
    write_reg(mdap_pkg::CFG_FACTOR, 11'h7ff);
    write_reg(mdap_pkg::CFG_MODE, 11'd1);
    big_ch = $urandom_range(0, mdap_pkg::DEF_CHANNELS - 1);
    for (int n = 0; n < mdap_pkg::DEF_MAX_FACTOR; n++) begin
      push_sample(rand_sample(), mdap_pkg::CHAN_W'(big_ch));
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
